/* src/mam_pkg.sv */
// Shared types, constants and helpers for the matrix add/multiply block.
package mam_pkg;

  function automatic int ELEMENT_PAD_CHECK(input int w);
    return w;
  endfunction

  localparam int MAX_DIM    = 16;
  localparam int ELEM_WIDTH = 16;

  localparam int ROW_W   = 4;
  localparam int ELEM_W  = 16;
  localparam int DIM_W   = 5;
  localparam int VALUE_W = 36;

  localparam int CELLS  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CNT_W  = $clog2(MAX_DIM + 1);
  localparam int PROD_W = 2 * ELEMENT_PAD_CHECK(ELEM_WIDTH);

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(16);
  localparam logic [DIM_W-1:0] DIM_CAP   = DIM_W'(MAX_DIM);

  typedef enum logic [1:0] {
    ACT_LOAD_A  = 2'd0,
    ACT_LOAD_B  = 2'd1,
    ACT_SUM     = 2'd2,
    ACT_PRODUCT = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DONE
  } state_t;

  // Flat cell address of (r, c) in a MAX_DIM x MAX_DIM array.
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                  input logic [ROW_W-1:0] c);
    return ADDR_W'(r) * ADDR_W'(MAX_DIM) + ADDR_W'(c);
  endfunction

endpackage

/* src/matrix_add_multiply.sv */
// Top level: two square matrix stores and a shared multiply-accumulate sequencer.
//
//   channel | direction | handshake             | payload
//   in_     | input     | in_valid / in_ready   | action, row, column, element
//   out_    | output    | out_valid / out_ready | value, out_of_range
//   cfg_    | input     | cfg_valid / cfg_ready | dimension
//
// A load completes on its transfer; a read walks the read-data and term
// registers into the accumulator, and an out-of-range read goes straight to
// the result; the product loop issues one memory read pair and one multiply
// per cycle.
// Reset is synchronous, active low; matrix contents are undefined until loaded.
// A finished result waits in the output register; in_ready is low during each
// read, and a second result waits in ST_DONE until the first has been taken.
module matrix_add_multiply
  import mam_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_action,
  input  logic [ROW_W-1:0]          in_row,
  input  logic [ROW_W-1:0]          in_column,
  input  logic signed [ELEM_W-1:0]  in_element,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [VALUE_W-1:0] out_value,
  output logic                      out_out_of_range,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [DIM_W-1:0]          cfg_dimension
);

  state_t st_r, st_nxt;

  logic [DIM_W-1:0]  dim_r;
  logic [DIM_W-1:0]  dim_eff;
  logic [ROW_W-1:0]  row_r, col_r;
  logic              sum_r;
  logic [CNT_W-1:0]  k_r, n_r;
  logic              rd_v_r, term_v_r;
  logic signed [VALUE_W-1:0] term_r, acc_r;
  logic              oor_r;

  logic              out_valid_r, out_oor_r;
  logic signed [VALUE_W-1:0] out_value_r;

  logic              in_xfer, in_range, is_load, start_read;
  logic              issue, out_free, out_load;
  action_t           act;

  logic              we_a, we_b;
  logic [ADDR_W-1:0] waddr, raddr_a, raddr_b;
  logic [ELEMENT_PAD_CHECK(ELEM_WIDTH)-1:0] rdata_a, rdata_b;
  logic [ROW_W-1:0]  k_idx;

  logic signed [ELEM_WIDTH-1:0] opa, opb;
  logic signed [PROD_W-1:0]     prod;
  logic signed [ELEM_WIDTH:0]   psum;
  logic signed [VALUE_W-1:0]    term_nxt;

  assign act      = action_t'(in_action);
  assign dim_eff  = (dim_r > DIM_CAP) ? DIM_CAP : dim_r;
  assign in_range = (DIM_W'(in_row) < dim_eff) && (DIM_W'(in_column) < dim_eff);
  assign in_ready = (st_r == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign is_load  = (act == ACT_LOAD_A) || (act == ACT_LOAD_B);
  assign start_read = in_xfer && !is_load;
  assign cfg_ready  = 1'b1;

  assign out_free = !out_valid_r || out_ready;

  // Storage
  assign we_a  = in_xfer && (act == ACT_LOAD_A) && in_range;
  assign we_b  = in_xfer && (act == ACT_LOAD_B) && in_range;
  assign waddr = cell_addr(in_row, in_column);

  // Sum reads use (row, col) in both stores; product reads walk k.
  assign k_idx   = k_r[ROW_W-1:0];
  assign raddr_a = cell_addr(row_r, sum_r ? col_r : k_idx);
  assign raddr_b = cell_addr(sum_r ? row_r : k_idx, col_r);

  mam_ram #(.DEPTH(CELLS), .WIDTH(ELEMENT_PAD_CHECK(ELEM_WIDTH))) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (in_element[ELEMENT_PAD_CHECK(ELEM_WIDTH)-1:0]),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  mam_ram #(.DEPTH(CELLS), .WIDTH(ELEMENT_PAD_CHECK(ELEM_WIDTH))) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (in_element[ELEMENT_PAD_CHECK(ELEM_WIDTH)-1:0]),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  // Shared arithmetic: multiply for products, add for sums
  assign opa  = rdata_a;
  assign opb  = rdata_b;
  assign prod = opa * opb;
  assign psum = {opa[ELEMENT_PAD_CHECK(ELEM_WIDTH)-1], opa}
              + {opb[ELEMENT_PAD_CHECK(ELEM_WIDTH)-1], opb};

  always_comb begin
    if (sum_r) begin
      term_nxt = {{(VALUE_W-ELEMENT_PAD_CHECK(ELEM_WIDTH)-1){psum[ELEMENT_PAD_CHECK(ELEM_WIDTH)]}},
                  psum};
    end else begin
      term_nxt = {{(VALUE_W-PROD_W){prod[PROD_W-1]}}, prod};
    end
  end

  // Sequencer
  always_comb begin
    st_nxt   = st_r;
    issue    = 1'b0;
    out_load = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (start_read) begin
          st_nxt = in_range ? ST_MAC : ST_DONE;
        end
      end
      ST_MAC: begin
        issue = (k_r < n_r);
        if (!issue && !rd_v_r && !term_v_r) begin
          st_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          st_nxt   = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      dim_r    <= DIM_RESET;
      rd_v_r   <= 1'b0;
      term_v_r <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      rd_v_r   <= issue;
      term_v_r <= rd_v_r;
      if (cfg_valid && cfg_ready) begin
        dim_r <= cfg_dimension;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_read) begin
      row_r <= in_row;
      col_r <= in_column;
      sum_r <= (act == ACT_SUM);
      n_r   <= (act == ACT_SUM) ? CNT_W'(1) : CNT_W'(dim_eff);
      k_r   <= '0;
      acc_r <= '0;
      oor_r <= !in_range;
    end else begin
      if (issue) begin
        k_r <= k_r + CNT_W'(1);
      end
      if (term_v_r) begin
        acc_r <= acc_r + term_r;
      end
    end
    if (rd_v_r) begin
      term_r <= term_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value_r <= acc_r;
      out_oor_r   <= oor_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_value        = out_value_r;
  assign out_out_of_range = out_oor_r;

endmodule

/* src/mam_ram.sv */
// Single-write, single-read RAM with registered read data.
module mam_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* src/mam_check.sv */
// Port-level checks for the matrix add/multiply block, bound to the top level.
module mam_check
  import mam_pkg::*;
(
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic [1:0]                in_action,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [VALUE_W-1:0] out_value,
  input logic                      out_out_of_range
);

  // A result that is not taken holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value)
                                && $stable(out_out_of_range))
    else $error("result changed while stalled");

  // Out-of-range reads report zero.
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |-> out_value == '0)
    else $error("out-of-range result with nonzero value");

  // A load with nothing pending produces no result.
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid
    && (in_action == ACT_LOAD_A || in_action == ACT_LOAD_B) |=> !out_valid)
    else $error("load produced a result");

  // A read transfer keeps the block busy in the next cycle.
  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready
    && (in_action == ACT_SUM || in_action == ACT_PRODUCT) |=> !in_ready)
    else $error("ready right after a read transfer");

endmodule

bind matrix_add_multiply mam_check u_mam_check (.*);

/* dv/tb.sv */
// Testbench for matrix_add_multiply: random load, sum and product traffic checked in-line.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mam_pkg::*;

  localparam int IDLE_PCT       = 13;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 2 * (MAX_DIM + 4);
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int CALM_FROM      = 1500;
  localparam int CALM_TO        = 6000;

  typedef enum {FILL_RANDOM, FILL_MIN} fill_mode_t;

  typedef struct {
    action_t                  action;
    logic [ROW_W-1:0]         row;
    logic [ROW_W-1:0]         column;
    logic signed [ELEM_W-1:0] element;
  } mat_op_t;

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    logic                      out_of_range;
  } mat_result_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [1:0]                in_action = '0;
  logic [ROW_W-1:0]          in_row = '0;
  logic [ROW_W-1:0]          in_column = '0;
  logic signed [ELEM_W-1:0]  in_element = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [VALUE_W-1:0] out_value;
  logic                      out_out_of_range;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [DIM_W-1:0]          cfg_dimension = '0;

  matrix_add_multiply u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_row           (in_row),
    .in_column        (in_column),
    .in_element       (in_element),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_value        (out_value),
    .out_out_of_range (out_out_of_range),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_dimension    (cfg_dimension)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // stimulus side
  mat_op_t          op_queue[$];
  mat_op_t          drive_op;
  int               ops_pushed = 0;
  logic [DIM_W-1:0] gen_dim = DIM_RESET;
  bit               gen_written_a [CELLS];
  bit               gen_written_b [CELLS];

  // prediction side
  logic signed [ELEM_W-1:0] mirror_a [CELLS];
  logic signed [ELEM_W-1:0] mirror_b [CELLS];
  logic [DIM_W-1:0]         mirror_dim = DIM_RESET;
  logic [DIM_W-1:0]         mirror_span;
  mat_op_t                  taken_op;
  mat_result_t              due_results[$];
  mat_result_t              head_due;
  int                       ops_taken = 0;

  int  mismatch_count = 0;
  int  cycle_no = 0;
  int  quiet_cycles = 0;
  int  hold_left = 0;
  bit  hold_req = 1'b0;
  bit  hold_done = 1'b0;
  logic calm;

  assign calm = (cycle_no >= CALM_FROM) && (cycle_no < CALM_TO);

  function automatic logic [DIM_W-1:0] effective_span(input logic [DIM_W-1:0] d);
    return (d > DIM_CAP) ? DIM_CAP : d;
  endfunction

  // Sum or product element for a read, from the mirrored matrices.
  function automatic mat_result_t compute_element(input mat_op_t op,
                                                  input logic [DIM_W-1:0] span);
    mat_result_t               res;
    logic signed [VALUE_W-1:0] acc;
    int                        k;
    acc = '0;
    res.out_of_range = !((op.row < span) && (op.column < span));
    if (!res.out_of_range) begin
      if (op.action == ACT_SUM) begin
        acc = mirror_a[{op.row, op.column}] + mirror_b[{op.row, op.column}];
      end else begin
        for (k = 0; k < span; k++) begin
          acc = acc + mirror_a[{op.row, ROW_W'(k)}] * mirror_b[{ROW_W'(k), op.column}];
        end
      end
    end
    res.value = acc;
    return res;
  endfunction

  function automatic logic signed [ELEM_W-1:0] random_element();
    case ($urandom_range(7))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  task automatic note_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t ns: %s", $time, msg);
  endtask

  task automatic push_op(input action_t act, input int r, input int c,
                         input logic signed [ELEM_W-1:0] e);
    mat_op_t          op;
    logic [DIM_W-1:0] span;
    span = effective_span(gen_dim);
    op.action  = act;
    op.row     = ROW_W'(r);
    op.column  = ROW_W'(c);
    op.element = e;
    op_queue.push_back(op);
    ops_pushed++;
    if (r < int'(span) && c < int'(span)) begin
      if (act == ACT_LOAD_A) gen_written_a[{ROW_W'(r), ROW_W'(c)}] = 1'b1;
      else if (act == ACT_LOAD_B) gen_written_b[{ROW_W'(r), ROW_W'(c)}] = 1'b1;
    end
  endtask

  task automatic push_random_op(input logic [DIM_W-1:0] span);
    int      roll;
    int      r;
    int      c;
    action_t act;
    roll = $urandom_range(99);
    act  = ($urandom_range(1) == 0) ? ACT_SUM : ACT_PRODUCT;
    r    = $urandom_range(15);
    c    = $urandom_range(15);
    if (span == 0) begin
      // nothing is in range: stray loads and flagged reads only
      act = action_t'($urandom_range(3));
    end else if (roll < 30) begin
      act = ($urandom_range(1) == 0) ? ACT_LOAD_A : ACT_LOAD_B;
      r   = $urandom_range(int'(span) - 1);
      c   = $urandom_range(int'(span) - 1);
    end else if (roll < 38) begin
      act = ($urandom_range(1) == 0) ? ACT_LOAD_A : ACT_LOAD_B;
    end else if (roll < 88 || span == DIM_CAP) begin
      act = (roll < 62) ? ACT_SUM : ACT_PRODUCT;
      r   = $urandom_range(int'(span) - 1);
      c   = $urandom_range(int'(span) - 1);
    end else begin
      r = $urandom_range(int'(span) - 1);
      c = $urandom_range(int'(span) - 1);
      case ($urandom_range(2))
        0: r = $urandom_range(15, int'(span));
        1: c = $urandom_range(15, int'(span));
        default: begin
          r = $urandom_range(15, int'(span));
          c = $urandom_range(15, int'(span));
        end
      endcase
    end
    push_op(act, r, c, random_element());
  endtask

  task automatic wait_quiet();
    while (ops_taken != ops_pushed || due_results.size() != 0) @(posedge clk);
    // loads leave no result behind, so give the block time to finish
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_dimension(input logic [DIM_W-1:0] d);
    cfg_valid     <= 1'b1;
    cfg_dimension <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    gen_dim = d;
  endtask

  task automatic run_phase(input logic [DIM_W-1:0] d, input int n, input fill_mode_t mode,
                           input bit squeeze);
    logic [DIM_W-1:0] span;
    wait_quiet();
    write_dimension(d);
    span = effective_span(d);
    // every cell in range gets written before anything reads it
    for (int r = 0; r < span; r++) begin
      for (int c = 0; c < span; c++) begin
        if (!gen_written_a[{ROW_W'(r), ROW_W'(c)}])
          push_op(ACT_LOAD_A, r, c, (mode == FILL_MIN) ? 16'sh8000 : random_element());
        if (!gen_written_b[{ROW_W'(r), ROW_W'(c)}])
          push_op(ACT_LOAD_B, r, c, (mode == FILL_MIN) ? 16'sh8000 : random_element());
      end
    end
    if (mode == FILL_MIN && span != 0) begin
      push_op(ACT_PRODUCT, int'(span) - 1, int'(span) - 1, 16'sh7FFF);
      push_op(ACT_SUM, int'(span) - 1, int'(span) - 1, 16'sh7FFF);
    end
    if (squeeze) hold_req = 1'b1;
    repeat (n) push_random_op(span);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: single-element matrices, extreme values, out-of-range traffic
    write_dimension(5'd1);
    push_op(ACT_LOAD_A, 0, 0, 16'sh8000);
    push_op(ACT_LOAD_B, 0, 0, 16'sh8000);
    push_op(ACT_SUM, 0, 0, 16'sh0000);
    push_op(ACT_PRODUCT, 0, 0, 16'sh7FFF);
    push_op(ACT_LOAD_A, 0, 0, 16'sh7FFF);
    push_op(ACT_PRODUCT, 0, 0, 16'sh0000);
    push_op(ACT_LOAD_B, 0, 0, 16'sh7FFF);
    push_op(ACT_SUM, 0, 0, 16'sh8000);
    push_op(ACT_PRODUCT, 0, 0, 16'shFFFF);
    // loads outside the dimension must not land anywhere
    push_op(ACT_LOAD_A, 0, 1, 16'sh0000);
    push_op(ACT_LOAD_B, 15, 15, 16'sh1234);
    push_op(ACT_LOAD_A, 1, 0, 16'sh0000);
    push_op(ACT_SUM, 0, 0, 16'sh0000);
    push_op(ACT_PRODUCT, 0, 0, 16'sh0000);
    push_op(ACT_SUM, 15, 15, 16'sh0000);
    push_op(ACT_PRODUCT, 0, 15, 16'sh0000);
    push_op(ACT_SUM, 15, 0, 16'sh5A5A);
    push_op(ACT_PRODUCT, 7, 9, 16'shA5A5);
    push_op(ACT_LOAD_A, 0, 0, 16'sh0000);
    push_op(ACT_PRODUCT, 0, 0, 16'sh0000);
    push_op(ACT_LOAD_B, 0, 0, 16'shFFFF);
    push_op(ACT_SUM, 0, 0, 16'sh0000);

    run_phase(5'd4, 95, FILL_RANDOM, 1'b0);
    run_phase(5'd0, 40, FILL_RANDOM, 1'b0);
    run_phase(5'd31, 95, FILL_MIN, 1'b0);
    run_phase(5'd2, 95, FILL_RANDOM, 1'b0);
    run_phase(5'd16, 125, FILL_RANDOM, 1'b1);
    run_phase(5'd9, 95, FILL_RANDOM, 1'b0);
    run_phase(5'd17, 95, FILL_RANDOM, 1'b0);
    run_phase(5'd1, 75, FILL_RANDOM, 1'b0);
    run_phase(5'd12, 105, FILL_RANDOM, 1'b0);
    wait_quiet();

    if (mismatch_count == 0 && due_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // sender: a new item only once the previous one is transferred
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (op_queue.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        drive_op = op_queue.pop_front();
        in_valid   <= 1'b1;
        in_action  <= drive_op.action;
        in_row     <= drive_op.row;
        in_column  <= drive_op.column;
        in_element <= drive_op.element;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random backpressure plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // predictor: mirrors stores and dimension on every transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      mirror_dim = DIM_RESET;
    end else begin
      if (cfg_valid && cfg_ready) mirror_dim = cfg_dimension;
      if (in_valid && in_ready) begin
        taken_op.action  = action_t'(in_action);
        taken_op.row     = in_row;
        taken_op.column  = in_column;
        taken_op.element = in_element;
        mirror_span = effective_span(mirror_dim);
        case (taken_op.action)
          ACT_LOAD_A: begin
            if (in_row < mirror_span && in_column < mirror_span)
              mirror_a[{in_row, in_column}] = in_element;
          end
          ACT_LOAD_B: begin
            if (in_row < mirror_span && in_column < mirror_span)
              mirror_b[{in_row, in_column}] = in_element;
          end
          default: due_results.push_back(compute_element(taken_op, mirror_span));
        endcase
        ops_taken++;
      end
    end
  end

  // result check against the oldest predicted element
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        note_error($sformatf("unexpected result: value=%0d out_of_range=%0b",
                             out_value, out_out_of_range));
      end else begin
        head_due = due_results.pop_front();
        if (out_value !== head_due.value)
          note_error($sformatf("value mismatch: expected %0d, got %0d",
                               head_due.value, out_value));
        if (out_out_of_range !== head_due.out_of_range)
          note_error($sformatf("out_of_range mismatch: expected %0b, got %0b",
                               head_due.out_of_range, out_out_of_range));
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      cycle_no <= cycle_no + 1;
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", quiet_cycles);
        $display("Simulation FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule

/* sim.f */
src/mam_pkg.sv
src/mam_ram.sv
src/matrix_add_multiply.sv
src/mam_check.sv
dv/tb.sv
